FILE: hdl/tsct_pkg.sv
// ----------------------------------------------------------------------------
// tsct_pkg
// Shared types and constants for the transmit submit/confirm tracker.
// ----------------------------------------------------------------------------
package tsct_pkg;

  localparam int unsigned SlotsDefault = 4;

  typedef enum logic {
    CMD_SUBMIT  = 1'b0,
    CMD_CONFIRM = 1'b1
  } cmd_e;

  // Token that walks the cell row: two passes, search then apply.
  typedef struct packed {
    logic        valid;
    logic        apply;    // 0: search pass, 1: apply pass
    cmd_e        cmd;
    logic        hit;      // key seen somewhere in the row (search pass)
    logic        found;    // slot written or freed (apply pass)
    logic [31:0] key;
    logic [7:0]  queue;
    logic [7:0]  tid;
    logic [7:0]  vif;
    logic [7:0]  station;
    logic [31:0] flags;
    logic [31:0] status;
    logic [31:0] seq;
    logic [31:0] res_id;
    logic [7:0]  res_queue;
    logic [7:0]  res_tid;
    logic [7:0]  res_vif;
    logic [7:0]  res_station;
    logic [31:0] res_flags;
  } tok_t;

  typedef struct packed {
    logic [31:0] sequence_id;
    logic [31:0] confirm_status;
    logic [7:0]  submit_queue;
    logic [7:0]  confirm_queue;
    logic [7:0]  stored_tid;
    logic [7:0]  stored_vif;
    logic [7:0]  stored_station;
    logic [31:0] stored_flags;
  } res_t;

endpackage

FILE: hdl/tsct_if.sv
// ----------------------------------------------------------------------------
// tsct_in_if / tsct_out_if
// Valid/ready channels of the tracker: event items in, result items out.
// ----------------------------------------------------------------------------
interface tsct_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] descriptor_key;
  logic [7:0]  queue;
  logic [7:0]  tid;
  logic [7:0]  vif;
  logic [7:0]  station;
  logic [31:0] flags;
  logic [31:0] status;

  modport source (
    output valid, command, descriptor_key, queue, tid, vif, station, flags, status,
    input  ready
  );
  modport sink (
    input  valid, command, descriptor_key, queue, tid, vif, station, flags, status,
    output ready
  );
endinterface

interface tsct_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sequence_id;
  logic [31:0] confirm_status;
  logic [7:0]  submit_queue;
  logic [7:0]  confirm_queue;
  logic [7:0]  stored_tid;
  logic [7:0]  stored_vif;
  logic [7:0]  stored_station;
  logic [31:0] stored_flags;

  modport source (
    output valid, sequence_id, confirm_status, submit_queue, confirm_queue,
           stored_tid, stored_vif, stored_station, stored_flags,
    input  ready
  );
  modport sink (
    input  valid, sequence_id, confirm_status, submit_queue, confirm_queue,
           stored_tid, stored_vif, stored_station, stored_flags,
    output ready
  );
endinterface

FILE: hdl/tsct_cell.sv
// ----------------------------------------------------------------------------
// tsct_cell
// One table slot. Compares the passing token against its key, updates the
// slot on the apply pass and hands the token to the next cell.
// ----------------------------------------------------------------------------
module tsct_cell
  import tsct_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  tok_t tok_i,
  output tok_t tok_o
);

  logic [31:0] key_q;
  logic [31:0] id_q;
  logic [31:0] flags_q;
  logic [7:0]  queue_q;
  logic [7:0]  tid_q;
  logic [7:0]  vif_q;
  logic [7:0]  station_q;
  tok_t        tok_q;
  tok_t        tok_d;
  logic        match;
  logic        wr;
  logic        clr;

  assign match = (key_q == tok_i.key);

  always_comb begin
    tok_d = tok_i;
    wr    = 1'b0;
    clr   = 1'b0;
    if (tok_i.valid) begin
      if (!tok_i.apply) begin
        if (match) tok_d.hit = 1'b1;
      end else if (tok_i.cmd == CMD_SUBMIT) begin
        // existing key wins; otherwise the first empty slot along the row
        if (tok_i.hit) wr = match;
        else           wr = (key_q == '0) && !tok_i.found;
        if (wr) tok_d.found = 1'b1;
      end else if (match) begin
        clr               = 1'b1;
        tok_d.found       = 1'b1;
        tok_d.res_id      = id_q;
        tok_d.res_queue   = queue_q;
        tok_d.res_tid     = tid_q;
        tok_d.res_vif     = vif_q;
        tok_d.res_station = station_q;
        tok_d.res_flags   = flags_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      tok_q <= '0;
    end else if (en_i) begin
      tok_q <= tok_d;
      if (wr)       key_q <= tok_i.key;
      else if (clr) key_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && wr) begin
      id_q      <= tok_i.seq;
      flags_q   <= tok_i.flags;
      queue_q   <= tok_i.queue;
      tid_q     <= tok_i.tid;
      vif_q     <= tok_i.vif;
      station_q <= tok_i.station;
    end
  end

  assign tok_o = tok_q;

endmodule

FILE: hdl/tx_submit_confirm_tracker_unit.sv
// ----------------------------------------------------------------------------
// tx_submit_confirm_tracker_unit
// Slot table pairing transmit submissions with their confirmations.
// ----------------------------------------------------------------------------
// in_i takes submit and confirm items; out_o gives one item per confirm that
// finds its key. A zero key is taken and dropped. Each item with a nonzero
// key is a token that walks the row of SLOTS cells twice: a search pass that
// notes whether the key is present, then an apply pass that writes,
// overwrites or frees the slot and picks up stored fields. An item therefore
// holds the block until both trips through the cell row are done; in_i.ready
// is low meanwhile. A confirm result is registered and shows on out_o once
// the apply pass ends, unless a result still pending on a stalled out_o holds
// the row. A full table drops a submit without advancing the sequence id.
// Reset empties every slot and clears the sequence counter; the block is
// ready straight after reset. If out_o is stalled with a result pending, the
// next input item is still taken; only a second result waiting to be loaded
// freezes the token in the last cell until out_o drains.
// ----------------------------------------------------------------------------
module tx_submit_confirm_tracker_unit
  import tsct_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tsct_in_if.sink   in_i,
  tsct_out_if.source out_o
);

  tok_t        tok [SLOTS];
  tok_t        head;
  tok_t        last;
  logic        busy_q, busy_d;
  logic [31:0] seq_q, seq_d;
  logic        out_valid_q, out_valid_d;
  res_t        res_q;
  logic        in_fire;
  logic        done;
  logic        load;
  logic        en;
  logic [SLOTS-1:0] tok_valid;

  assign last    = tok[SLOTS-1];
  assign in_fire = in_i.valid && in_i.ready;
  assign done    = last.valid && last.apply;
  assign load    = done && (last.cmd == CMD_CONFIRM) && last.found;
  assign en      = !(load && out_valid_q && !out_o.ready);

  assign in_i.ready = !busy_q;

  always_comb begin
    head = '0;
    if (last.valid && !last.apply) begin
      head       = last;
      head.apply = 1'b1;
    end else if (in_fire && (in_i.descriptor_key != '0)) begin
      head.valid   = 1'b1;
      head.cmd     = cmd_e'(in_i.command);
      head.key     = in_i.descriptor_key;
      head.queue   = in_i.queue;
      head.tid     = in_i.tid;
      head.vif     = in_i.vif;
      head.station = in_i.station;
      head.flags   = in_i.flags;
      head.status  = in_i.status;
      head.seq     = seq_q;
    end
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    tsct_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .tok_i ((i == 0) ? head : tok[(i == 0) ? 0 : i-1]),
      .tok_o (tok[i])
    );
    assign tok_valid[i] = tok[i].valid;
  end

  always_comb begin
    busy_d      = busy_q;
    seq_d       = seq_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) out_valid_d = 1'b0;
    if (in_fire && (in_i.descriptor_key != '0)) busy_d = 1'b1;
    if (done && en) begin
      busy_d = 1'b0;
      if ((last.cmd == CMD_SUBMIT) && last.found) seq_d = seq_q + 32'd1;
      if (load) out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      seq_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      seq_q       <= seq_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && en) begin
      res_q.sequence_id    <= last.res_id;
      res_q.confirm_status <= last.status;
      res_q.submit_queue   <= last.res_queue;
      res_q.confirm_queue  <= last.queue;
      res_q.stored_tid     <= last.res_tid;
      res_q.stored_vif     <= last.res_vif;
      res_q.stored_station <= last.res_station;
      res_q.stored_flags   <= last.res_flags;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.sequence_id    = res_q.sequence_id;
  assign out_o.confirm_status = res_q.confirm_status;
  assign out_o.submit_queue   = res_q.submit_queue;
  assign out_o.confirm_queue  = res_q.confirm_queue;
  assign out_o.stored_tid     = res_q.stored_tid;
  assign out_o.stored_vif     = res_q.stored_vif;
  assign out_o.stored_station = res_q.stored_station;
  assign out_o.stored_flags   = res_q.stored_flags;

  // only one item travels the row at a time
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_valid) <= 1)
    else $error("more than one token in the cell row");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (tok_valid == '0))
    else $error("token in the row while idle");

  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q != $past(seq_q)) |->
      ($past(done && en && (last.cmd == CMD_SUBMIT) && last.found)
       && (seq_q == $past(seq_q) + 32'd1)))
    else $error("sequence id moved without a stored submit");

  a_no_lost_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && out_valid_q && !out_o.ready) |=> (load && out_valid_q))
    else $error("pending result overwritten");

endmodule
